FILE: rtl/integer_pid_controller_unit_defines.svh
// Assertion macros for the PID controller RTL.
`ifndef INTEGER_PID_CONTROLLER_UNIT_DEFINES_SVH
`define INTEGER_PID_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ipc_pkg.sv
package ipc_pkg;

   // Fixed field widths
   localparam int ERR_W   = 25;
   localparam int RAW_W   = 26;
   localparam int DIFF_W  = 28;
   localparam int DT_W    = 27;
   localparam int INT_W   = 25;
   localparam int MULA_W  = 28;
   localparam int MULB_W  = 17;
   localparam int PROD_W  = MULA_W + MULB_W;
   localparam int FSUM_W  = 38;
   localparam int ACC_W   = 48;
   localparam int OUT_W   = 17;
   localparam int STEP_W  = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int FILT_SHIFT = 8;

   localparam int OUTPUT_SHIFT_DEFAULT = 16;

   localparam logic [23:0] INT_LIMIT_RESET = 24'h010000;
   localparam logic [15:0] OUT_LIMIT_RESET = 16'd1000;

   localparam logic signed [FSUM_W-1:0] DERIV_MAX = FSUM_W'(67108863);
   localparam logic signed [FSUM_W-1:0] DERIV_MIN = -FSUM_W'(67108864);

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KP        = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI        = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD        = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_CLAMP = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_CLAMP = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_LIMIT = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT = 4'd7;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [1:0] {
      MUL_KP_PC,
      MUL_FILT_DIFF,
      MUL_KD_DT,
      MUL_KI_INT
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_INIT,
      ACC_ADD
   } acc_op_type;

   // One microcode word
   typedef struct packed {
      logic              load_front;   // form raw derivative and clamped errors
      logic              load_diff;    // form raw minus filtered derivative
      logic              mul_en;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              dt_update;    // apply filter step
      logic              skip_filter;  // bypass filter when smoothing is zero
      logic [STEP_W-1:0] jump_to;
      logic              finish;       // write result and integral
   } ucode_type;

   localparam ucode_type UCODE_NOP = '{
      load_front:  1'b0,
      load_diff:   1'b0,
      mul_en:      1'b0,
      mul_sel:     MUL_KP_PC,
      acc_op:      ACC_HOLD,
      dt_update:   1'b0,
      skip_filter: 1'b0,
      jump_to:     '0,
      finish:      1'b0
   };

   // Control program, one word per step
   function automatic ucode_type ucode_rom(logic [STEP_W-1:0] step);
      ucode_type w;
      w = UCODE_NOP;
      unique case (step)
         3'd0: begin
            w.load_front = 1'b1;
            w.acc_op     = ACC_INIT;
         end
         3'd1: begin
            w.load_diff = 1'b1;
            w.mul_en    = 1'b1;
            w.mul_sel   = MUL_KP_PC;
         end
         3'd2: begin
            w.acc_op      = ACC_ADD;
            w.mul_en      = 1'b1;
            w.mul_sel     = MUL_FILT_DIFF;
            w.skip_filter = 1'b1;
            w.jump_to     = 3'd4;
         end
         3'd3: begin
            w.dt_update = 1'b1;
         end
         3'd4: begin
            w.mul_en  = 1'b1;
            w.mul_sel = MUL_KD_DT;
         end
         3'd5: begin
            w.acc_op  = ACC_ADD;
            w.mul_en  = 1'b1;
            w.mul_sel = MUL_KI_INT;
         end
         3'd6: begin
            w.acc_op = ACC_ADD;
         end
         3'd7: begin
            w.finish = 1'b1;
         end
      endcase
      return w;
   endfunction

   // Symmetric clamp of the error
   function automatic logic signed [ERR_W-1:0] clamp_err(logic signed [ERR_W-1:0] v,
                                                         logic [23:0] lim);
      logic signed [ERR_W-1:0] lim_s;
      lim_s = signed'({1'b0, lim});
      if (v > lim_s) return lim_s;
      if (v < -lim_s) return -lim_s;
      return v;
   endfunction

   // Symmetric clamp of the grown integral
   function automatic logic signed [INT_W-1:0] clamp_int(logic signed [INT_W:0] v,
                                                         logic [23:0] lim);
      logic signed [INT_W:0] lim_s;
      lim_s = signed'({2'b0, lim});
      if (v > lim_s) return INT_W'(lim_s);
      if (v < -lim_s) return INT_W'(-lim_s);
      return INT_W'(v);
   endfunction

   // Symmetric clamp of the shifted sum to the output limit
   function automatic logic signed [OUT_W-1:0] clamp_out(logic signed [ACC_W-1:0] v,
                                                         logic [15:0] lim);
      logic signed [ACC_W-1:0] lim_s;
      lim_s = signed'(ACC_W'(lim));
      if (v > lim_s) return OUT_W'(lim_s);
      if (v < -lim_s) return OUT_W'(-lim_s);
      return OUT_W'(v);
   endfunction

endpackage

FILE: rtl/integer_pid_controller_unit.sv
// Each input transaction runs the eight-step control program on one shared 28x17
// multiplier to form its result; with smoothing at zero the filter step is skipped.
// A new item is taken once the program ends, while the previous result still waits in
// the output register. A result held by the receiver stalls the last step until the
// output register frees.
// Reset: synchronous, active high; registers return to defaults, controller state to zero.
module integer_pid_controller_unit #(
   parameter int OUTPUT_SHIFT = ipc_pkg::OUTPUT_SHIFT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // setpoint [23:0], measured [47:24]
   input  logic [47:0] req_tdata,
   // do_integrate [0]
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // drive_output [16:0], zero [23:17]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ipc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipc_pkg::CSR_DATA_W-1:0] csr_data
);

`include "integer_pid_controller_unit_defines.svh"

   localparam logic signed [ipc_pkg::ACC_W-1:0] ROUND_BIAS =
      ipc_pkg::ACC_W'(1) <<< (OUTPUT_SHIFT - 1);

   // Configuration registers
   logic [15:0] kp_ff, ki_ff, kd_ff;
   logic [23:0] err_clamp_ff, int_clamp_ff, int_limit_ff;
   logic [8:0]  smooth_ff;
   logic [15:0] out_limit_ff;

   // Sequencer
   ipc_pkg::seq_state_type    state_ff, state_in;
   logic [ipc_pkg::STEP_W-1:0] step_ff, step_in;
   ipc_pkg::ucode_type         uw;
   logic                       accept, fire;

   // Datapath
   logic signed [ipc_pkg::ERR_W-1:0]  err_ff, prev_ff, pcp_ff, pci_ff;
   logic                              int_en_ff;
   logic signed [ipc_pkg::RAW_W-1:0]  raw_ff;
   logic signed [ipc_pkg::DIFF_W-1:0] diff_ff;
   logic signed [ipc_pkg::DT_W-1:0]   dt_ff;
   logic signed [ipc_pkg::INT_W-1:0]  integ_ff;
   logic signed [ipc_pkg::PROD_W-1:0] prod_ff;
   logic signed [ipc_pkg::ACC_W-1:0]  acc_ff;
   logic signed [ipc_pkg::OUT_W-1:0]  result_ff;
   logic                              rsp_valid_ff;

   logic signed [ipc_pkg::MULA_W-1:0] mul_a;
   logic signed [ipc_pkg::MULB_W-1:0] mul_b;
   logic signed [ipc_pkg::FSUM_W-1:0] filt_sum;
   logic signed [ipc_pkg::INT_W:0]    integ_sum;
   logic signed [ipc_pkg::ACC_W-1:0]  acc_shifted;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ipc_pkg::SEQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, result_ff};

   assign uw = ipc_pkg::ucode_rom(step_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         err_clamp_ff <= '0;
         int_clamp_ff <= '0;
         smooth_ff    <= '0;
         int_limit_ff <= ipc_pkg::INT_LIMIT_RESET;
         out_limit_ff <= ipc_pkg::OUT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ipc_pkg::CSR_KP:        kp_ff        <= csr_data[15:0];
            ipc_pkg::CSR_KI:        ki_ff        <= csr_data[15:0];
            ipc_pkg::CSR_KD:        kd_ff        <= csr_data[15:0];
            ipc_pkg::CSR_ERR_CLAMP: err_clamp_ff <= csr_data;
            ipc_pkg::CSR_INT_CLAMP: int_clamp_ff <= csr_data;
            ipc_pkg::CSR_SMOOTH:    smooth_ff    <= csr_data[8:0];
            ipc_pkg::CSR_INT_LIMIT: int_limit_ff <= csr_data;
            ipc_pkg::CSR_OUT_LIMIT: out_limit_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipc_pkg::SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Advance the program, jump past the filter, hold the last step on a full output
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      fire     = 1'b0;
      unique case (state_ff)
         ipc_pkg::SEQ_IDLE: begin
            if (accept) begin
               state_in = ipc_pkg::SEQ_RUN;
               step_in  = '0;
            end
         end
         ipc_pkg::SEQ_RUN: begin
            priority if (uw.finish) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  fire     = 1'b1;
                  state_in = ipc_pkg::SEQ_IDLE;
                  step_in  = '0;
               end
            end else if (uw.skip_filter && smooth_ff == '0) begin
               step_in = uw.jump_to;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = ipc_pkg::SEQ_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Select multiplier operands
   always_comb begin
      unique case (uw.mul_sel)
         ipc_pkg::MUL_KP_PC: begin
            mul_a = ipc_pkg::MULA_W'(pcp_ff);
            mul_b = signed'({1'b0, kp_ff});
         end
         ipc_pkg::MUL_FILT_DIFF: begin
            mul_a = diff_ff;
            mul_b = signed'(ipc_pkg::MULB_W'(smooth_ff));
         end
         ipc_pkg::MUL_KD_DT: begin
            mul_a = ipc_pkg::MULA_W'(dt_ff);
            mul_b = signed'({1'b0, kd_ff});
         end
         ipc_pkg::MUL_KI_INT: begin
            mul_a = ipc_pkg::MULA_W'(integ_ff);
            mul_b = signed'({1'b0, ki_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign filt_sum    = ipc_pkg::FSUM_W'(dt_ff)
                      + ipc_pkg::FSUM_W'(prod_ff >>> ipc_pkg::FILT_SHIFT);
   assign integ_sum   = (ipc_pkg::INT_W+1)'(integ_ff) + (ipc_pkg::INT_W+1)'(pci_ff);
   assign acc_shifted = acc_ff >>> OUTPUT_SHIFT;

   // Capture the transaction, then run the program steps
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         dt_ff    <= '0;
         integ_ff <= '0;
      end else begin
         if (accept) begin
            err_ff    <= ipc_pkg::ERR_W'(signed'(req_tdata[23:0]))
                       - ipc_pkg::ERR_W'(signed'(req_tdata[47:24]));
            int_en_ff <= req_tuser;
         end
         if (state_ff == ipc_pkg::SEQ_RUN) begin
            if (uw.load_front) begin
               raw_ff  <= ipc_pkg::RAW_W'(err_ff) - ipc_pkg::RAW_W'(prev_ff);
               prev_ff <= err_ff;
               pcp_ff  <= (err_clamp_ff != '0) ? ipc_pkg::clamp_err(err_ff, err_clamp_ff)
                                               : err_ff;
               pci_ff  <= (int_clamp_ff != '0) ? ipc_pkg::clamp_err(err_ff, int_clamp_ff)
                                               : err_ff;
            end
            if (uw.load_diff) begin
               diff_ff <= ipc_pkg::DIFF_W'(raw_ff) - ipc_pkg::DIFF_W'(dt_ff);
            end
            if (uw.skip_filter && smooth_ff == '0) begin
               dt_ff <= ipc_pkg::DT_W'(raw_ff);
            end
            if (uw.dt_update) begin
               priority if (filt_sum > ipc_pkg::DERIV_MAX)
                  dt_ff <= ipc_pkg::DT_W'(ipc_pkg::DERIV_MAX);
               else if (filt_sum < ipc_pkg::DERIV_MIN)
                  dt_ff <= ipc_pkg::DT_W'(ipc_pkg::DERIV_MIN);
               else
                  dt_ff <= ipc_pkg::DT_W'(filt_sum);
            end
            if (uw.mul_en) begin
               prod_ff <= mul_a * mul_b;
            end
            unique case (uw.acc_op)
               ipc_pkg::ACC_INIT: acc_ff <= ROUND_BIAS;
               ipc_pkg::ACC_ADD:  acc_ff <= acc_ff + ipc_pkg::ACC_W'(prod_ff);
               default: ;
            endcase
            if (fire) begin
               result_ff <= ipc_pkg::clamp_out(acc_shifted, out_limit_ff);
               if (int_en_ff && ki_ff != '0) begin
                  integ_ff <= ipc_pkg::clamp_int(integ_sum, int_limit_ff);
               end
            end
         end
      end
   end

   // Hold the result until the downstream transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   `IPC_ASSERT_NEXT(a_accept_starts, accept,
      (state_ff == ipc_pkg::SEQ_RUN) && (step_ff == '0),
      "accepted transaction did not start the program at step zero")
   `IPC_ASSERT_NEXT(a_finish_presents, fire,
      rsp_valid_ff && (state_ff == ipc_pkg::SEQ_IDLE),
      "finished program did not present a result")
   `IPC_ASSERT_NOW(a_output_bounded, rsp_valid_ff,
      (result_ff <= signed'({2'b0, out_limit_ff}))
         && (result_ff >= -signed'({2'b0, out_limit_ff})),
      "result exceeds the output limit")

endmodule

FILE: bench/integer_pid_controller_unit_test.sv
`timescale 1ns / 1ps

module integer_pid_controller_unit_test;

   localparam int SHIFT            = ipc_pkg::OUTPUT_SHIFT_DEFAULT;
   localparam int HOLDOFF_CYCLES   = 300;
   localparam int SETTLE_CYCLES    = 12;
   localparam int RANDOM_PHASES    = 8;
   localparam int TICKS_PER_PHASE  = 88;
   localparam longint DERIV_HI     = 64'sd67108863;
   localparam longint DERIV_LO     = -64'sd67108864;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [47:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [ipc_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [ipc_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   // Idle controls: sender gap odds (main process), receiver stall odds
   int req_gap_pct    = 0;
   int rsp_stall_pct  = 0;
   int holdoff_asked  = 0;
   int holdoff_served = 0;
   int holdoff_cnt    = 0;

   // Tracks controller state and the queue of expected drive outputs
   class pid_scoreboard;
      logic [15:0]        kp, ki, kd, out_lim;
      logic [23:0]        err_clamp, int_clamp, int_lim;
      logic [8:0]         smooth;
      logic signed [24:0] last_err;
      logic signed [26:0] deriv;
      logic signed [24:0] integral;
      logic signed [16:0] drive_q[$];
      int                 failures;

      function new();
         kp        = '0;
         ki        = '0;
         kd        = '0;
         err_clamp = '0;
         int_clamp = '0;
         smooth    = '0;
         int_lim   = ipc_pkg::INT_LIMIT_RESET;
         out_lim   = ipc_pkg::OUT_LIMIT_RESET;
         last_err  = '0;
         deriv     = '0;
         integral  = '0;
         failures  = 0;
      endfunction

      function longint sym_limit(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void write_reg(logic [ipc_pkg::CSR_IDX_W-1:0] idx,
                              logic [ipc_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            ipc_pkg::CSR_KP:        kp        = value[15:0];
            ipc_pkg::CSR_KI:        ki        = value[15:0];
            ipc_pkg::CSR_KD:        kd        = value[15:0];
            ipc_pkg::CSR_ERR_CLAMP: err_clamp = value;
            ipc_pkg::CSR_INT_CLAMP: int_clamp = value;
            ipc_pkg::CSR_SMOOTH:    smooth    = value[8:0];
            ipc_pkg::CSR_INT_LIMIT: int_lim   = value;
            ipc_pkg::CSR_OUT_LIMIT: out_lim   = value[15:0];
            default: ;
         endcase
      endfunction

      // Advance one control tick and queue its drive output
      function void note_tick(logic [47:0] data, logic integ_en);
         logic signed [23:0] sp, ms;
         longint err, raw, d, pc, acc, res, isum;
         sp  = data[23:0];
         ms  = data[47:24];
         err = longint'(sp) - longint'(ms);
         raw = err - longint'(last_err);
         if (smooth == '0) begin
            d = raw;
         end else begin
            d = longint'(deriv) + (((raw - longint'(deriv)) * longint'(smooth)) >>> 8);
            if (d > DERIV_HI) d = DERIV_HI;
            if (d < DERIV_LO) d = DERIV_LO;
         end
         deriv    = d[26:0];
         last_err = err[24:0];

         pc = err;
         if (err_clamp != '0) pc = sym_limit(pc, longint'(err_clamp));
         acc = longint'(kp) * pc + longint'(kd) * d + longint'(ki) * longint'(integral)
               + (longint'(1) << (SHIFT - 1));
         res = sym_limit(acc >>> SHIFT, longint'(out_lim));

         // Integrate after the output is formed
         if (integ_en && ki != '0) begin
            pc = err;
            if (int_clamp != '0) pc = sym_limit(pc, longint'(int_clamp));
            isum     = sym_limit(longint'(integral) + pc, longint'(int_lim));
            integral = isum[24:0];
         end
         drive_q.push_back(res[16:0]);
      endfunction

      function void check_drive(logic [23:0] beat);
         logic signed [16:0] want;
         if (drive_q.size() == 0) begin
            $display("%0t: drive_output with none expected: actual %0d",
                     $time, signed'(beat[16:0]));
            failures++;
         end else begin
            want = drive_q.pop_front();
            if (beat[16:0] !== want) begin
               $display("%0t: drive_output mismatch: expected %0d, actual %0d",
                        $time, want, signed'(beat[16:0]));
               failures++;
            end
            if (beat[23:17] !== '0) begin
               $display("%0t: rsp_tdata padding mismatch: expected 0, actual 'h%0h",
                        $time, beat[23:17]);
               failures++;
            end
         end
      endfunction
   endclass

   pid_scoreboard tracker;

   integer_pid_controller_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (holdoff_cnt > 0) begin
         holdoff_cnt <= holdoff_cnt - 1;
         rsp_tready  <= 1'b0;
      end else if (holdoff_asked != holdoff_served) begin
         holdoff_served <= holdoff_asked;
         holdoff_cnt    <= HOLDOFF_CYCLES;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Observe every transaction; check results before noting new ticks
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_drive(rsp_tdata);
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) tracker.note_tick(req_tdata, req_tuser);
      end
   end

   task automatic send_tick(logic [23:0] sp, logic [23:0] ms, logic integ);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < req_gap_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {ms, sp};
      req_tuser  <= integ;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(logic [ipc_pkg::CSR_IDX_W-1:0] idx,
                            logic [ipc_pkg::CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                logic [23:0] ec, logic [23:0] ic, logic [8:0] sm,
                                logic [23:0] il, logic [15:0] ol);
      csr_write(ipc_pkg::CSR_KP, 24'(kp));
      csr_write(ipc_pkg::CSR_KI, 24'(ki));
      csr_write(ipc_pkg::CSR_KD, 24'(kd));
      csr_write(ipc_pkg::CSR_ERR_CLAMP, ec);
      csr_write(ipc_pkg::CSR_INT_CLAMP, ic);
      csr_write(ipc_pkg::CSR_SMOOTH, 24'(sm));
      csr_write(ipc_pkg::CSR_INT_LIMIT, il);
      csr_write(ipc_pkg::CSR_OUT_LIMIT, 24'(ol));
      csr_valid <= 1'b0;
   endtask

   // Drop valid, let the last transaction be noted, wait for every result,
   // then let the pipeline go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.drive_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] draw_reg(int width);
      logic [23:0] mask;
      mask = (24'd1 << width) - 24'd1;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return mask;
         default: return (24'($urandom()) & mask) >> $urandom_range(0, width - 1);
      endcase
   endfunction

   function automatic logic [23:0] draw_value(int min_shift);
      return 24'(signed'(24'($urandom())) >>> $urandom_range(min_shift, 23));
   endfunction

   // Mostly tracking runs around a held setpoint, the rest full-range noise
   task automatic random_ticks(int count);
      logic [23:0] sp;
      int run_left;
      sp = '0;
      run_left = 0;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_tick(24'($urandom()), 24'($urandom()), 1'($urandom_range(0, 1)));
         end else begin
            if (run_left == 0) begin
               sp = draw_value(0);
               run_left = $urandom_range(4, 30);
            end
            run_left--;
            send_tick(sp, sp - draw_value(4), $urandom_range(0, 9) != 0);
         end
      end
   endtask

   initial begin
      #5000000;
      $display("[integer_pid_controller_unit] ERROR");
      $finish;
   end

   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: all gains zero
      send_tick(24'd5, 24'd0, 1'b1);
      send_tick(24'h7FFFFF, 24'h800000, 1'b1);
      settle();

      // Full gains, no clamps, filter bypassed: extreme errors both ways
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 24'd0, 9'd0,
                    24'hFFFFFF, 16'hFFFF);
      send_tick(24'h7FFFFF, 24'h800000, 1'b1);
      send_tick(24'h800000, 24'h7FFFFF, 1'b1);
      send_tick(24'h000000, 24'h000000, 1'b0);
      send_tick(24'h000001, 24'h000000, 1'b1);
      send_tick(24'hFFFFFF, 24'h000000, 1'b1);
      settle();

      // Smoothing above unity gain drives the derivative into saturation;
      // zero integral limit and zero output limit
      load_settings(16'd1, 16'hFFFF, 16'd256, 24'd1, 24'hFFFFFF, 9'h1FF,
                    24'd0, 16'd0);
      send_tick(24'h7FFFFF, 24'h800000, 1'b1);
      send_tick(24'h800000, 24'h7FFFFF, 1'b1);
      send_tick(24'h7FFFFF, 24'h800000, 1'b1);
      send_tick(24'h800000, 24'h7FFFFF, 1'b1);
      settle();

      // Unity filter, tight integrate clamp, output limit of one
      load_settings(16'hFFFF, 16'd1, 16'd0, 24'hFFFFFF, 24'd1, 9'd256,
                    24'hFFFFFF, 16'd1);
      send_tick(24'h000010, 24'hFFFFF0, 1'b1);
      send_tick(24'hFFFFF0, 24'h000010, 1'b1);
      send_tick(24'h400000, 24'hC00000, 1'b0);
      send_tick(24'h000000, 24'h000003, 1'b1);
      settle();

      // Moderate gains with light filtering and active clamps
      load_settings(16'd300, 16'd2000, 16'd5000, 24'd1000, 24'd100, 9'd1,
                    24'd5000, 16'hFFFF);
      send_tick(24'd1500, 24'd0, 1'b1);
      send_tick(24'd1500, 24'd900, 1'b1);
      send_tick(24'd1500, 24'd1600, 1'b1);
      send_tick(24'd1500, 24'd1500, 1'b0);
      settle();

      // Random settings, cycling through the idle patterns
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_settings(draw_reg(16), draw_reg(16), draw_reg(16), draw_reg(24),
                       draw_reg(24), draw_reg(9), draw_reg(24), draw_reg(16));
         case (ph % 4)
            0: begin
               req_gap_pct = 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               req_gap_pct = 60;
               rsp_stall_pct <= 0;
            end
            2: begin
               req_gap_pct = 0;
               rsp_stall_pct <= 60;
            end
            default: begin
               req_gap_pct = 36;
               rsp_stall_pct <= 36;
            end
         endcase
         // Hold the receiver off while the sender keeps pushing
         if (ph == 0) holdoff_asked <= holdoff_asked + 1;
         random_ticks(TICKS_PER_PHASE);
         settle();
      end

      if (tracker.failures == 0) begin
         $display("[integer_pid_controller_unit] OK");
      end else begin
         $display("[integer_pid_controller_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/ipc_pkg.sv
rtl/integer_pid_controller_unit.sv
bench/integer_pid_controller_unit_test.sv
